>>> hw/rtl/stins_pkg.sv
// Shared constants, codes and types for the sorted key table.
// No dependencies; every other file of the block but stins_ram imports this package.
package stins_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STAT_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LINEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BINARY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
  } stins_mem_req_t;

endpackage

>>> hw/rtl/stins_req_if.sv
// Request channel of the sorted key table: valid/ready plus request payload.
// Depends on stins_pkg.
interface stins_req_if
  import stins_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [CMD_W-1:0]  cmd;
  logic signed [KEY_W-1:0]  new_key;
  logic        [IDX_W-1:0]  read_index;

  modport source (output valid, cmd, new_key, read_index, input ready);
  modport sink   (input valid, cmd, new_key, read_index, output ready);
endinterface

>>> hw/rtl/stins_rsp_if.sv
// Response channel of the sorted key table: valid/ready plus result payload.
// Depends on stins_pkg.
interface stins_rsp_if
  import stins_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [POS_W-1:0]  position;
  logic signed [KEY_W-1:0]  read_key;
  logic        [POS_W-1:0]  entry_count;
  logic        [STAT_W-1:0] status;

  modport source (output valid, position, read_key, entry_count, status, input ready);
  modport sink   (input valid, position, read_key, entry_count, status, output ready);
endinterface

>>> hw/rtl/stins_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stins_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/stins_ctrl.sv
// Sequencer of the sorted key table: search, shift, key write, read, result register.
// Depends on stins_pkg, stins_req_if, stins_rsp_if; drives the table RAM.
module stins_ctrl
  import stins_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  stins_req_if.sink        req_i,
  stins_rsp_if.source      rsp_o,
  output stins_mem_req_t   mem_req_o,
  input  logic [KEY_W-1:0] mem_rdata_i
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LSRCH   = 4'd1;
  localparam logic [3:0] S_BPROBE  = 4'd2;
  localparam logic [3:0] S_BCMP    = 4'd3;
  localparam logic [3:0] S_SHSTART = 4'd4;
  localparam logic [3:0] S_SHIFT   = 4'd5;
  localparam logic [3:0] S_WKEY    = 4'd6;
  localparam logic [3:0] S_RDWAIT  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]         low_q, low_d;
  logic [CNT_W-1:0]         hi1_q, hi1_d;
  logic [CNT_W-1:0]         mid_q, mid_d;
  logic                     lt_q, lt_d;
  logic [POS_W-1:0]         res_pos_q, res_pos_d;
  logic signed [KEY_W-1:0]  res_key_q, res_key_d;
  logic [STAT_W-1:0]        res_stat_q, res_stat_d;
  logic                     out_valid_q, out_valid_d;
  logic [POS_W-1:0]         out_pos_q, out_pos_d;
  logic signed [KEY_W-1:0]  out_key_q, out_key_d;
  logic [POS_W-1:0]         out_cnt_q, out_cnt_d;
  logic [STAT_W-1:0]        out_stat_q, out_stat_d;
  logic                     out_load;
  logic signed [KEY_W-1:0]  rd_key;
  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         ptr_inc, ptr_dec;
  stins_mem_req_t           mem_req;

  assign rd_key  = $signed(mem_rdata_i);
  assign mid_sum = {1'b0, low_q} + {1'b0, hi1_q} - (CNT_W+1)'(1);
  assign ptr_inc = ptr_q + CNT_W'(1);
  assign ptr_dec = ptr_q - CNT_W'(1);

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    key_d      = key_q;
    pos_d      = pos_q;
    ptr_d      = ptr_q;
    low_d      = low_q;
    hi1_d      = hi1_q;
    mid_d      = mid_q;
    lt_d       = lt_q;
    res_pos_d  = res_pos_q;
    res_key_d  = res_key_q;
    res_stat_d = res_stat_q;
    mem_req    = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d      = req_i.new_key;
          res_pos_d  = '0;
          res_key_d  = '0;
          res_stat_d = ST_OK;
          case (req_i.cmd)
            CMD_LINEAR, CMD_BINARY: begin
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                res_stat_d = ST_FULL;
                state_d    = S_DONE;
              end else if (cnt_q == '0) begin
                pos_d   = '0;
                state_d = S_SHSTART;
              end else if (req_i.cmd == CMD_LINEAR) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                ptr_d         = '0;
                state_d       = S_LSRCH;
              end else begin
                low_d   = '0;
                hi1_d   = cnt_q;
                lt_d    = 1'b0;
                mid_d   = '0;
                state_d = S_BPROBE;
              end
            end
            CMD_READ: begin
              res_pos_d = POS_W'(req_i.read_index);
              if (CNT_W'(req_i.read_index) < cnt_q) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(req_i.read_index);
                state_d       = S_RDWAIT;
              end else begin
                res_stat_d = ST_RANGE;
                state_d    = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_LSRCH: begin
        if (rd_key >= key_q) begin
          pos_d   = ptr_q;
          state_d = S_SHSTART;
        end else if (ptr_inc == cnt_q) begin
          pos_d   = cnt_q;
          state_d = S_SHSTART;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc[ADDR_W-1:0];
          ptr_d         = ptr_inc;
        end
      end
      S_BPROBE: begin
        if (low_q < hi1_q) begin
          mid_d         = mid_sum[CNT_W:1];
          mem_req.re    = 1'b1;
          mem_req.raddr = mid_sum[ADDR_W:1];
          state_d       = S_BCMP;
        end else begin
          pos_d   = lt_q ? mid_q : mid_q + CNT_W'(1);
          state_d = S_SHSTART;
        end
      end
      S_BCMP: begin
        if (key_q == rd_key) begin
          pos_d   = mid_q;
          state_d = S_SHSTART;
        end else if (key_q < rd_key) begin
          hi1_d   = mid_q;
          lt_d    = 1'b1;
          state_d = S_BPROBE;
        end else begin
          low_d   = mid_q + CNT_W'(1);
          lt_d    = 1'b0;
          state_d = S_BPROBE;
        end
      end
      S_SHSTART: begin
        if (pos_q >= cnt_q) begin
          pos_d   = cnt_q;
          state_d = S_WKEY;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(cnt_q - CNT_W'(1));
          ptr_d         = cnt_q;
          state_d       = S_SHIFT;
        end
      end
      S_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_q[ADDR_W-1:0];
        mem_req.wdata = mem_rdata_i;
        if (ptr_dec == pos_q) begin
          state_d = S_WKEY;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(ptr_q - CNT_W'(2));
          ptr_d         = ptr_dec;
        end
      end
      S_WKEY: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q[ADDR_W-1:0];
        mem_req.wdata = key_q;
        cnt_d         = cnt_q + CNT_W'(1);
        res_pos_d     = POS_W'(pos_q);
        state_d       = S_DONE;
      end
      S_RDWAIT: begin
        res_key_d = rd_key;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_key_d   = out_key_q;
    out_cnt_d   = out_cnt_q;
    out_stat_d  = out_stat_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_pos_d   = res_pos_q;
      out_key_d   = res_key_q;
      out_cnt_d   = POS_W'(cnt_q);
      out_stat_d  = res_stat_q;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pos_q      <= pos_d;
    ptr_q      <= ptr_d;
    low_q      <= low_d;
    hi1_q      <= hi1_d;
    mid_q      <= mid_d;
    lt_q       <= lt_d;
    res_pos_q  <= res_pos_d;
    res_key_q  <= res_key_d;
    res_stat_q <= res_stat_d;
    out_pos_q  <= out_pos_d;
    out_key_q  <= out_key_d;
    out_cnt_q  <= out_cnt_d;
    out_stat_q <= out_stat_d;
  end

  assign mem_req_o         = mem_req;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.position    = out_pos_q;
  assign rsp_o.read_key    = out_key_q;
  assign rsp_o.entry_count = out_cnt_q;
  assign rsp_o.status      = out_stat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("entry count changed by other than one");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("table read and write at the same entry");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (CNT_W'(mem_req.waddr) <= cnt_q))
    else $error("table write above the fill level");

  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == S_SHIFT || state_q == S_WKEY))
    else $error("table write outside an insert");

endmodule

>>> hw/rtl/sorted_table_insert_top.sv
// Sorted key table: an ascending table of signed 32-bit keys in one RAM with
// a fill count. Each request gives one response. An insert searches for its
// slot (linear: entries are read upward from slot 0 until a key not below the
// new key is found or the end is reached; binary: each probe reads one entry,
// then compares it), moves the entries above that slot up one place at one
// entry per cycle, and writes the key. A binary insert at slot 0 of a
// 127-entry table takes 7 probes.
// The table RAM has a single read and a single write port.
// One request is worked at a time; the next is taken while the response
// waits in its output register. The table needs no clearing after reset.
// Depends on stins_pkg, stins_req_if, stins_rsp_if, stins_ctrl, stins_ram.
module sorted_table_insert_top
  import stins_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  stins_req_if.sink    req_i,
  stins_rsp_if.source  rsp_o
);

  stins_mem_req_t   mem_req;
  logic [KEY_W-1:0] mem_rdata;

  stins_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  stins_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
